/* rtl/mmws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmws_pkg
// Shared constants, codes and types of the max mean window search core.
// ----------------------------------------------------------------------------
package mmws_pkg;

    // Default sizes
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF   = 12;

    // Result and register widths
    localparam int MEAN_W     = 32;
    localparam int BIT_W      = $clog2(MEAN_W);
    localparam int CFG_W      = 13;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register index, taken from paddr[2]
    localparam logic REG_MIN_LENGTH = 1'b0;

    localparam logic [CFG_W-1:0] MIN_LENGTH_RST = CFG_W'(1);

    // Per-step control handed from the sequencer to the test pass datapath
    typedef struct packed {
        logic clear;     // start a new test pass
        logic step;      // a step is issued this cycle
        logic use_min;   // window of min_length fits: compare this step
        logic min_zero;  // the older running minimum is the initial zero
        logic k_one;     // min_length of one: take the live minimum
        logic k_two;     // min_length of two: take the delayed minimum
    } pass_ctl_t;

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_ISSUE  = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

/* rtl/mmws_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmws_in_if
// Sample request channel: valid/ready handshake with sample and last flag.
// ----------------------------------------------------------------------------
interface mmws_in_if #(
    parameter int SAMPLE_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/mmws_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmws_out_if
// Result request channel: valid/ready handshake with mean and status flags.
// ----------------------------------------------------------------------------
interface mmws_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_mean;
    logic        valid_res;
    logic        overflowed;

    modport source (output valid, output max_mean, output valid_res,
                    output overflowed, input ready);
    modport sink   (input valid, input max_mean, input valid_res,
                    input overflowed, output ready);
endinterface

/* rtl/mmws_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmws_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mmws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; a read of the entry being written returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mmws_pass.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmws_pass
// Test pass datapath: prefix sum of (sample - trial), running minimum kept
// in a RAM, and the window check against the minimum min_length back.
// ----------------------------------------------------------------------------
module mmws_pass
    import mmws_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pass_ctl_t                      ctl,
    input  logic [$clog2(MAX_SAMPLES)-1:0] min_raddr,
    input  logic [$clog2(MAX_SAMPLES)-1:0] min_waddr,
    input  logic [MEAN_W-1:0]              trial,
    input  logic [SAMPLE_BITS-1:0]         sample_rdata,
    output logic                           hit
);

    localparam int AW      = $clog2(MAX_SAMPLES);
    localparam int CW      = $clog2(MAX_SAMPLES + 1);
    localparam int SHIFT_W = SAMPLE_BITS + FRAC_BITS;
    localparam int TERM_W  = ((SHIFT_W > MEAN_W) ? SHIFT_W : MEAN_W) + 1;
    localparam int SUM_W   = TERM_W + CW;

    pass_ctl_t          a_ctl_reg;
    logic [AW-1:0]      a_waddr_reg;
    pass_ctl_t          b_ctl_reg;
    logic [AW-1:0]      b_waddr_reg;
    logic [TERM_W-1:0]  b_term_reg;
    logic [SUM_W-1:0]   b_mk_reg;
    logic [SUM_W-1:0]   p_reg;
    logic [SUM_W-1:0]   rm_reg;
    logic [SUM_W-1:0]   rm_d1_reg;
    logic               hit_reg;

    logic [SUM_W-1:0]   min_rdata;
    logic [TERM_W-1:0]  term_a;
    logic [SUM_W-1:0]   term_ext;
    logic [SUM_W-1:0]   p_next;
    logic [SUM_W-1:0]   rm_next;
    logic [SUM_W-1:0]   mk;
    logic               reach;

    // Running minimum store, one entry per position
    mmws_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SAMPLES)
    ) u_min_ram (
        .clk   (clk),
        .we    (b_ctl_reg.step),
        .waddr (b_waddr_reg),
        .wdata (rm_next),
        .raddr (min_raddr),
        .rdata (min_rdata)
    );

    // Stage A: scaled sample minus trial mean
    assign term_a = TERM_W'({sample_rdata, {FRAC_BITS{1'b0}}}) - TERM_W'(trial);

    // Stage B: advance prefix sum and running minimum, check the window
    assign term_ext = {{(SUM_W - TERM_W){b_term_reg[TERM_W-1]}}, b_term_reg};
    assign p_next   = p_reg + term_ext;
    assign rm_next  = ($signed(p_next) < $signed(rm_reg)) ? p_next : rm_reg;

    // Pick the older minimum; short windows bypass the RAM write latency
    always_comb
    begin
        if (b_ctl_reg.min_zero)
        begin
            mk = '0;
        end
        else if (b_ctl_reg.k_one)
        begin
            mk = rm_reg;
        end
        else if (b_ctl_reg.k_two)
        begin
            mk = rm_d1_reg;
        end
        else
        begin
            mk = b_mk_reg;
        end
    end

    assign reach = b_ctl_reg.use_min && ($signed(p_next) >= $signed(mk));

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= ctl;
            b_ctl_reg <= a_ctl_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        a_waddr_reg <= min_waddr;
        b_waddr_reg <= a_waddr_reg;
        b_term_reg  <= term_a;
        b_mk_reg    <= min_rdata;
    end

    // Pass accumulators: clear at pass start, advance on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg     <= '0;
            rm_reg    <= '0;
            rm_d1_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            p_reg     <= '0;
            rm_reg    <= '0;
            rm_d1_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else if (b_ctl_reg.step)
        begin
            p_reg     <= p_next;
            rm_reg    <= rm_next;
            rm_d1_reg <= rm_reg;
            if (reach)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    assign hit = hit_reg;

endmodule

/* rtl/max_mean_window_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_mean_window_search_core
// Stores a sample sequence, then finds the largest Q20.12 mean reached by a
// window of at least min_length samples, one result bit per test pass.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+----------------------------------------
//  smp     | in  | valid / ready | sample, last
//  res     | out | valid / ready | max_mean, valid_res, overflowed
//  apb     | in  | psel/penable  | paddr, pwdata, prdata (min_length)
//
//  Samples load one per cycle into the sample RAM.
//  After the last sample, if at least min_length samples are stored, 32 test
//  passes run, each stepping through the sample and minimum RAMs, draining
//  the pipeline and deciding one result bit; then the result is posted.
//  smp.ready is low during the search; the result register holds until taken.
//  rst_n clears all control state asynchronously; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module max_mean_window_search_core
    import mmws_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mmws_in_if.sink               smp,
    mmws_out_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  min_len_reg, min_len_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [CFG_W-1:0]  k_reg, k_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [MEAN_W-1:0] cand_reg, cand_next;
    logic              valid_reg, valid_next;
    logic              drain_reg, drain_next;
    logic              out_vld_reg, out_vld_next;
    logic [MEAN_W-1:0] out_mean_reg, out_mean_next;
    logic              out_vres_reg, out_vres_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              acc;
    logic              full;
    logic [CW-1:0]     cnt_after;
    logic [CFG_W-1:0]  k_eff;
    logic              enough;
    logic              cfg_wr;
    logic [CW-1:0]     i_dec;
    logic [CMP_W-1:0]  min_idx;
    logic [MEAN_W-1:0] trial;
    logic [SAMPLE_BITS-1:0] sample_rdata;
    logic              hit;
    logic              post;
    pass_ctl_t         ctl;

    // Input handshake and load bookkeeping
    assign smp.ready = (state_reg == ST_LOAD);
    assign acc       = smp.valid && smp.ready;
    assign full      = (count_reg == CW'(MAX_SAMPLES));
    assign cnt_after = full ? count_reg : CW'(count_reg + CW'(1));
    assign k_eff     = (min_len_reg == '0) ? CFG_W'(1) : min_len_reg;
    assign enough    = (CMP_W'(k_eff) <= CMP_W'(cnt_after));

    // Step addresses and trial mean
    assign i_dec   = CW'(i_reg - CW'(1));
    assign min_idx = CMP_W'(CMP_W'(i_reg) - CMP_W'(k_reg) - CMP_W'(1));
    assign trial   = cand_reg | (MEAN_W'(1) << bit_reg);

    // Per-step control for the test pass datapath
    always_comb
    begin
        ctl          = '0;
        ctl.clear    = (state_reg == ST_LOAD && acc && smp.last && enough) ||
                       (state_reg == ST_DECIDE && bit_reg != '0);
        ctl.step     = (state_reg == ST_ISSUE);
        ctl.use_min  = (CMP_W'(i_reg) >= CMP_W'(k_reg));
        ctl.min_zero = (CMP_W'(i_reg) == CMP_W'(k_reg));
        ctl.k_one    = (k_reg == CFG_W'(1));
        ctl.k_two    = (k_reg == CFG_W'(2));
    end

    // Sample store
    mmws_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_sample_ram (
        .clk   (clk),
        .we    (acc && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata (smp.sample),
        .raddr (i_dec[AW-1:0]),
        .rdata (sample_rdata)
    );

    mmws_pass #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_pass (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .min_raddr    (min_idx[AW-1:0]),
        .min_waddr    (i_dec[AW-1:0]),
        .trial        (trial),
        .sample_rdata (sample_rdata),
        .hit          (hit)
    );

    // Configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_MIN_LENGTH) ?
                    APB_DATA_W'(min_len_reg) : '0;

    // Result register: load from the done state when free or being taken
    assign post = (state_reg == ST_DONE) && (!out_vld_reg || res.ready);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        min_len_next  = min_len_reg;
        count_next    = count_reg;
        drop_next     = drop_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        bit_next      = bit_reg;
        cand_next     = cand_reg;
        valid_next    = valid_reg;
        drain_next    = drain_reg;
        out_vld_next  = out_vld_reg;
        out_mean_next = out_mean_reg;
        out_vres_next = out_vres_reg;
        out_ovf_next  = out_ovf_reg;

        if (cfg_wr && paddr[APB_ADDR_W-1] == REG_MIN_LENGTH)
        begin
            min_len_next = pwdata[CFG_W-1:0];
        end

        // Drop the result once taken
        if (res.ready && out_vld_reg)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (acc)
                begin
                    count_next = cnt_after;
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    if (smp.last)
                    begin
                        cand_next = '0;
                        bit_next  = BIT_W'(MEAN_W - 1);
                        i_next    = CW'(1);
                        k_next    = k_eff;
                        if (enough)
                        begin
                            valid_next = 1'b1;
                            state_next = ST_ISSUE;
                        end
                        else
                        begin
                            valid_next = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_ISSUE:
            begin
                if (i_reg == count_reg)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    i_next = CW'(i_reg + CW'(1));
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (hit)
                begin
                    cand_next = trial;
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next   = BIT_W'(bit_reg - BIT_W'(1));
                    i_next     = CW'(1);
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (post)
                begin
                    out_vld_next  = 1'b1;
                    out_mean_next = cand_reg;
                    out_vres_next = valid_reg;
                    out_ovf_next  = drop_reg;
                    count_next    = '0;
                    drop_next     = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            min_len_reg <= MIN_LENGTH_RST;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            i_reg       <= CW'(1);
            bit_reg     <= BIT_W'(MEAN_W - 1);
            cand_reg    <= '0;
            valid_reg   <= 1'b0;
            drain_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            k_reg       <= CFG_W'(1);
        end
        else
        begin
            state_reg   <= state_next;
            min_len_reg <= min_len_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            i_reg       <= i_next;
            bit_reg     <= bit_next;
            cand_reg    <= cand_next;
            valid_reg   <= valid_next;
            drain_reg   <= drain_next;
            out_vld_reg <= out_vld_next;
            k_reg       <= k_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_mean_reg <= out_mean_next;
        out_vres_reg <= out_vres_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign res.valid      = out_vld_reg;
    assign res.max_mean   = out_mean_reg;
    assign res.valid_res  = out_vres_reg;
    assign res.overflowed = out_ovf_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |-> (i_reg != '0) && (i_reg <= count_reg))
        else $error("step index outside stored samples");

    a_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) && (bit_reg == '0) |=> state_reg == ST_DONE)
        else $error("search did not finish after the last bit");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.valid_res |-> res.max_mean == '0)
        else $error("nonzero mean on a short sequence");

endmodule
